@@ hw/rtl/pole_pkg.sv @@
// ----------------------------------------------------------------------------
// pole_pkg
// Shared codes, defaults and types of the positional ordered list engine.
// ----------------------------------------------------------------------------
package pole_pkg;

   localparam int DEFAULT_CAPACITY = 32;

   localparam int OP_W    = 3;
   localparam int POS_W   = 6;
   localparam int VALUE_W = 32;
   localparam int STAT_W  = 2;

   localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
   localparam logic [OP_W-1:0] OP_HEAD    = 3'd1;
   localparam logic [OP_W-1:0] OP_INSERT  = 3'd2;
   localparam logic [OP_W-1:0] OP_GET     = 3'd3;
   localparam logic [OP_W-1:0] OP_FIND    = 3'd4;
   localparam logic [OP_W-1:0] OP_DELETE  = 3'd5;

   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd1;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic ins;
      logic del;
   } cell_cmd_type;

endpackage

@@ hw/rtl/pole_cell.sv @@
// ----------------------------------------------------------------------------
// pole_cell
// One list entry. Shifts toward the tail on insert, toward the head on
// delete, and compares its entry against the search key.
// ----------------------------------------------------------------------------
module pole_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 6
) (
   input  logic                                 clock,
   input  pole_pkg::cell_cmd_type               cmd,
   input  logic [CNT_W-1:0]                     slot,
   input  logic [CNT_W-1:0]                     count,
   input  logic signed [pole_pkg::VALUE_W-1:0]  key,
   input  logic signed [pole_pkg::VALUE_W-1:0]  left_value,
   input  logic signed [pole_pkg::VALUE_W-1:0]  right_value,
   output logic signed [pole_pkg::VALUE_W-1:0]  entry,
   output logic                                 match
);

   localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

   logic signed [pole_pkg::VALUE_W-1:0] entry_ff;
   logic signed [pole_pkg::VALUE_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins) begin
         if (MY_INDEX == slot) begin
            entry_in = key;
         end else if (MY_INDEX > slot) begin
            entry_in = left_value;
         end
      end else if (cmd.del) begin
         if (MY_INDEX >= slot) begin
            entry_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   // Cells at or past the count hold stale data and never match.
   assign match = (MY_INDEX < count) && (entry_ff == key);

endmodule

@@ hw/rtl/positional_ordered_list_engine.sv @@
// ----------------------------------------------------------------------------
// positional_ordered_list_engine
// Ordered list of signed values kept in a chain of shifting cells.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Its operation code,
// 1-based position and value are on the req_ ports in that cycle. All cells
// shift, load or compare together at the edge that takes the item, so the
// whole list changes at that one edge.
// In the next cycle the result is on the rsp_ ports with rsp_valid high for
// that one cycle; busy is high in that same cycle, so no new item is taken
// while a result is shown. While it is shown, the registered match vector
// is turned into the first matching position. The receiver cannot stall;
// each result is simply shown once.
// Reset empties the list (count zero) and drops any pending result. Stored
// entries are not cleared; entries past the count are never read.
// ----------------------------------------------------------------------------
module positional_ordered_list_engine #(
   parameter int CAPACITY = pole_pkg::DEFAULT_CAPACITY
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [pole_pkg::OP_W-1:0]            req_op,
   input  logic [pole_pkg::POS_W-1:0]           req_position,
   input  logic signed [pole_pkg::VALUE_W-1:0]  req_item_value,
   output logic                                 rsp_valid,
   output logic [pole_pkg::STAT_W-1:0]          rsp_status,
   output logic signed [pole_pkg::VALUE_W-1:0]  rsp_read_value,
   output logic [pole_pkg::POS_W-1:0]           rsp_found_position,
   output logic [pole_pkg::POS_W-1:0]           rsp_length
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMP_W = ((CNT_W > pole_pkg::POS_W) ? CNT_W : pole_pkg::POS_W) + 1;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

   logic                               busy_ff;
   logic [CNT_W-1:0]                   count_ff, count_in;
   logic [pole_pkg::STAT_W-1:0]        status_ff, status_in;
   logic signed [pole_pkg::VALUE_W-1:0] read_ff, read_in;
   logic                               find_ff, find_in;
   logic [CAPACITY-1:0]                match_ff;

   logic                               accept;
   pole_pkg::cell_cmd_type             cmd;
   logic [CNT_W-1:0]                   slot;
   logic [CMP_W-1:0]                   pos_x, cnt_x;
   logic                               full;
   logic                               read_en;

   logic signed [pole_pkg::VALUE_W-1:0] entry_vec [CAPACITY];
   logic [CAPACITY-1:0]                match_vec;

   assign accept = start && !busy_ff;
   assign pos_x  = CMP_W'(req_position);
   assign cnt_x  = CMP_W'(count_ff);
   assign full   = (count_ff == FULL_COUNT);

   always_comb begin
      cmd       = '0;
      slot      = '0;
      read_en   = 1'b0;
      status_in = pole_pkg::ST_OK;
      count_in  = count_ff;
      find_in   = 1'b0;
      unique case (req_op)
         pole_pkg::OP_APPEND: begin
            if (full) begin
               status_in = pole_pkg::ST_FULL;
            end else begin
               cmd.ins = 1'b1;
               slot    = count_ff;
            end
         end
         pole_pkg::OP_HEAD: begin
            if (full) begin
               status_in = pole_pkg::ST_FULL;
            end else begin
               cmd.ins = 1'b1;
            end
         end
         pole_pkg::OP_INSERT: begin
            if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) begin
               status_in = pole_pkg::ST_BADPOS;
            end else if (full) begin
               status_in = pole_pkg::ST_FULL;
            end else begin
               cmd.ins = 1'b1;
               slot    = CNT_W'(pos_x - CMP_W'(1));
            end
         end
         pole_pkg::OP_GET: begin
            if (pos_x == '0 || pos_x > cnt_x) begin
               status_in = pole_pkg::ST_BADPOS;
            end else begin
               read_en = 1'b1;
               slot    = CNT_W'(pos_x - CMP_W'(1));
            end
         end
         pole_pkg::OP_FIND: begin
            find_in = 1'b1;
         end
         pole_pkg::OP_DELETE: begin
            if (pos_x == '0 || pos_x > cnt_x) begin
               status_in = pole_pkg::ST_BADPOS;
            end else begin
               read_en = 1'b1;
               cmd.del = 1'b1;
               slot    = CNT_W'(pos_x - CMP_W'(1));
            end
         end
         default: begin
         end
      endcase
      if (cmd.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.del) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (!accept) begin
         cmd      = '0;
         count_in = count_ff;
      end
      read_in = read_en ? entry_vec[slot[IDX_W-1:0]] : '0;
   end

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic signed [pole_pkg::VALUE_W-1:0] left_value;
         logic signed [pole_pkg::VALUE_W-1:0] right_value;
         if (gi == 0) begin : g_head
            assign left_value = req_item_value;
         end else begin : g_mid
            assign left_value = entry_vec[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_tail
            assign right_value = entry_vec[gi];
         end else begin : g_body
            assign right_value = entry_vec[gi+1];
         end
         pole_cell #(
            .INDEX (gi),
            .CNT_W (CNT_W)
         ) u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .slot        (slot),
            .count       (count_ff),
            .key         (req_item_value),
            .left_value  (left_value),
            .right_value (right_value),
            .entry       (entry_vec[gi]),
            .match       (match_vec[gi])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= accept;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         read_ff   <= read_in;
         find_ff   <= find_in;
         match_ff  <= match_vec;
      end
   end

   // The lowest set match bit is isolated with a two's complement trick and
   // then encoded bit by bit.
   logic [CAPACITY-1:0] first_hit;
   logic [IDX_W-1:0]    hit_idx;
   logic                any_hit;
   logic [CMP_W-1:0]    fpos_x;
   logic [CMP_W-1:0]    len_x;

   always_comb begin
      first_hit = match_ff & (~match_ff + CAPACITY'(1));
      hit_idx   = '0;
      for (int b = 0; b < IDX_W; b++) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (((i >> b) & 1) != 0) begin
               hit_idx[b] = hit_idx[b] | first_hit[i];
            end
         end
      end
   end

   assign any_hit = |match_ff;
   assign fpos_x  = CMP_W'(hit_idx) + CMP_W'(1);
   assign len_x   = CMP_W'(count_ff);

   assign busy               = busy_ff;
   assign rsp_valid          = busy_ff;
   assign rsp_read_value     = read_ff;
   assign rsp_length         = len_x[pole_pkg::POS_W-1:0];
   assign rsp_status         = !find_ff ? status_ff
                             : (any_hit ? pole_pkg::ST_OK : pole_pkg::ST_NOTFOUND);
   assign rsp_found_position = (find_ff && any_hit) ? fpos_x[pole_pkg::POS_W-1:0] : '0;

endmodule
